[rtl/core/ilst_pkg.sv]
// ----------------------------------------------------------------------------
// ilst_pkg
// Shared widths, types and constants of the interval latency stats tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ilst_pkg;

   // field widths
   localparam int SEC_BITS       = 32;
   localparam int TOTAL_SEC_BITS = 40;
   localparam int NSEC_BITS      = 30;

   // wide enough to hold any seconds sum without wrapping
   localparam int WIDE_BITS =
      ((SEC_BITS > TOTAL_SEC_BITS) ? SEC_BITS : TOTAL_SEC_BITS) + 2;

   typedef logic [SEC_BITS-1:0]       sec_type;
   typedef logic [TOTAL_SEC_BITS-1:0] tot_sec_type;
   typedef logic [NSEC_BITS-1:0]      nsec_type;
   typedef logic [NSEC_BITS:0]        nsec_wide_type;
   typedef logic [WIDE_BITS-1:0]      wide_sec_type;
   typedef logic                      op_type;

   // nanosecond limits
   localparam nsec_type NS_PER_SEC = NSEC_BITS'(1000000000);
   localparam nsec_type NS_MAX     = NSEC_BITS'(999999999);

   // saturated value of the total seconds
   localparam tot_sec_type TOT_SEC_MAX = {TOTAL_SEC_BITS{1'b1}};

   // operation codes
   localparam op_type OP_INIT  = 1'b0;
   localparam op_type OP_ACCUM = 1'b1;

endpackage

`default_nettype wire

[rtl/core/ilst_if.sv]
// ----------------------------------------------------------------------------
// ilst_req_if / ilst_rsp_if
// Valid/ready channels for timestamp items and statistics results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ilst_req_if;
   logic                 valid;
   logic                 ready;
   ilst_pkg::op_type     op;
   ilst_pkg::sec_type    start_sec;
   ilst_pkg::nsec_type   start_nsec;
   ilst_pkg::sec_type    end_sec;
   ilst_pkg::nsec_type   end_nsec;

   modport source (output valid, output op, output start_sec, output start_nsec,
                   output end_sec, output end_nsec, input ready);
   modport sink   (input valid, input op, input start_sec, input start_nsec,
                   input end_sec, input end_nsec, output ready);
endinterface

interface ilst_rsp_if;
   logic                  valid;
   logic                  ready;
   ilst_pkg::sec_type     delta_sec;
   ilst_pkg::nsec_type    delta_nsec;
   ilst_pkg::tot_sec_type total_sec;
   ilst_pkg::nsec_type    total_nsec;
   ilst_pkg::sec_type     min_sec;
   ilst_pkg::nsec_type    min_nsec;
   ilst_pkg::sec_type     max_sec;
   ilst_pkg::nsec_type    max_nsec;
   logic                  total_saturated;
   logic                  order_error;

   modport source (output valid, output delta_sec, output delta_nsec,
                   output total_sec, output total_nsec, output min_sec,
                   output min_nsec, output max_sec, output max_nsec,
                   output total_saturated, output order_error, input ready);
   modport sink   (input valid, input delta_sec, input delta_nsec,
                   input total_sec, input total_nsec, input min_sec,
                   input min_nsec, input max_sec, input max_nsec,
                   input total_saturated, input order_error, output ready);
endinterface

`default_nettype wire

[rtl/core/interval_latency_stats_tracker_unit.sv]
// ----------------------------------------------------------------------------
// interval_latency_stats_tracker_unit
// Forms the interval between two sec/nsec timestamps and keeps the running
// total, minimum and maximum interval.
// ----------------------------------------------------------------------------
//  channel    dir   contents
//  req_chan   in    op, start_sec, start_nsec, end_sec, end_nsec
//  rsp_chan   out   delta, total, min, max, total_saturated, order_error
//
//  Two register stages: input register, then the interval, accumulate and
//  min/max logic writing the statistics and the result register together.
//  One item per cycle sustained while the result side is ready; each item's
//  result is offered from the result register. The statistics registers
//  drive the result directly; they change only when the next result is loaded.
//  Each stage stalls only when it is full and the stage after it is held;
//  synchronous reset empties both stages and restores the statistics.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_latency_stats_tracker_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   ilst_req_if.sink   req_chan,
   ilst_rsp_if.source rsp_chan
);

   // clamp nanoseconds to the legal range
   function automatic ilst_pkg::nsec_type clamp_ns(input ilst_pkg::nsec_type v);
      clamp_ns = (v > ilst_pkg::NS_MAX) ? ilst_pkg::NS_MAX : v;
   endfunction

   // input stage
   logic                  in_valid_ff, in_valid_in;
   ilst_pkg::op_type      in_op_ff;
   ilst_pkg::sec_type     in_ss_ff, in_es_ff;
   ilst_pkg::nsec_type    in_sn_ff, in_en_ff;

   // result stage
   logic                  out_valid_ff, out_valid_in;
   ilst_pkg::sec_type     delta_sec_ff, delta_sec_in;
   ilst_pkg::nsec_type    delta_nsec_ff, delta_nsec_in;
   logic                  order_error_ff, order_error_in;

   // statistics
   ilst_pkg::tot_sec_type tot_sec_ff, tot_sec_in;
   ilst_pkg::nsec_type    tot_nsec_ff, tot_nsec_in;
   ilst_pkg::sec_type     min_sec_ff, min_sec_in;
   ilst_pkg::nsec_type    min_nsec_ff, min_nsec_in;
   ilst_pkg::sec_type     max_sec_ff, max_sec_in;
   ilst_pkg::nsec_type    max_nsec_ff, max_nsec_in;
   logic                  sat_ff, sat_in;

   logic                  out_ready;
   logic                  in_ready;
   logic                  req_take;
   logic                  advance;

   logic                  err;
   logic                  borrow;
   ilst_pkg::nsec_wide_type ns_sum;
   logic                  ns_carry;
   ilst_pkg::nsec_type    ns_acc;
   ilst_pkg::wide_sec_type sec_acc;
   logic                  acc_over;
   logic                  init_over;
   logic                  new_min;
   logic                  new_max;

   // handshake
   assign out_ready      = !out_valid_ff || rsp_chan.ready;
   assign in_ready       = !in_valid_ff || out_ready;
   assign req_chan.ready = in_ready;
   assign req_take       = req_chan.valid && in_ready;
   assign advance        = in_valid_ff && out_ready;
   assign in_valid_in    = req_take || (in_valid_ff && !out_ready);
   assign out_valid_in   = advance || (out_valid_ff && !rsp_chan.ready);

   // interval and order check
   always_comb begin
      err = (in_es_ff < in_ss_ff) || ((in_es_ff == in_ss_ff) && (in_en_ff < in_sn_ff));
      borrow = in_en_ff < in_sn_ff;
      if (err) begin
         delta_sec_in  = '0;
         delta_nsec_in = '0;
      end else if (borrow) begin
         delta_sec_in  = in_es_ff - in_ss_ff - ilst_pkg::sec_type'(1);
         delta_nsec_in = ilst_pkg::NS_PER_SEC + in_en_ff - in_sn_ff;
      end else begin
         delta_sec_in  = in_es_ff - in_ss_ff;
         delta_nsec_in = in_en_ff - in_sn_ff;
      end
      order_error_in = err;
   end

   // accumulate with nanosecond carry and saturation check
   always_comb begin
      ns_sum   = {1'b0, tot_nsec_ff} + {1'b0, delta_nsec_in};
      ns_carry = ns_sum >= {1'b0, ilst_pkg::NS_PER_SEC};
      ns_acc   = ns_carry ? ilst_pkg::nsec_type'(ns_sum - {1'b0, ilst_pkg::NS_PER_SEC})
                          : ilst_pkg::nsec_type'(ns_sum);
      sec_acc  = ilst_pkg::wide_sec_type'(tot_sec_ff)
               + ilst_pkg::wide_sec_type'(delta_sec_in)
               + ilst_pkg::wide_sec_type'(ns_carry);
      acc_over  = sec_acc > ilst_pkg::wide_sec_type'(ilst_pkg::TOT_SEC_MAX);
      init_over = ilst_pkg::wide_sec_type'(delta_sec_in)
                > ilst_pkg::wide_sec_type'(ilst_pkg::TOT_SEC_MAX);
      new_min = (delta_sec_in < min_sec_ff)
             || ((delta_sec_in == min_sec_ff) && (delta_nsec_in < min_nsec_ff));
      new_max = (max_sec_ff < delta_sec_in)
             || ((max_sec_ff == delta_sec_in) && (max_nsec_ff < delta_nsec_in));
   end

   // next statistics
   always_comb begin
      tot_sec_in  = tot_sec_ff;
      tot_nsec_in = tot_nsec_ff;
      min_sec_in  = min_sec_ff;
      min_nsec_in = min_nsec_ff;
      max_sec_in  = max_sec_ff;
      max_nsec_in = max_nsec_ff;
      sat_in      = sat_ff;
      if (!err) begin
         case (in_op_ff)
            ilst_pkg::OP_INIT: begin
               if (init_over) begin
                  tot_sec_in  = ilst_pkg::TOT_SEC_MAX;
                  tot_nsec_in = ilst_pkg::NS_MAX;
                  sat_in      = 1'b1;
               end else begin
                  tot_sec_in  = ilst_pkg::tot_sec_type'(delta_sec_in);
                  tot_nsec_in = delta_nsec_in;
                  sat_in      = 1'b0;
               end
               min_sec_in  = delta_sec_in;
               min_nsec_in = delta_nsec_in;
               max_sec_in  = delta_sec_in;
               max_nsec_in = delta_nsec_in;
            end
            ilst_pkg::OP_ACCUM: begin
               if (acc_over) begin
                  tot_sec_in  = ilst_pkg::TOT_SEC_MAX;
                  tot_nsec_in = ilst_pkg::NS_MAX;
                  sat_in      = 1'b1;
               end else begin
                  tot_sec_in  = ilst_pkg::tot_sec_type'(sec_acc);
                  tot_nsec_in = ns_acc;
               end
               if (new_min) begin
                  min_sec_in  = delta_sec_in;
                  min_nsec_in = delta_nsec_in;
               end
               if (new_max) begin
                  max_sec_in  = delta_sec_in;
                  max_nsec_in = delta_nsec_in;
               end
            end
            default: begin
               sat_in = sat_ff;
            end
         endcase
      end
   end

   // control and statistics registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         tot_sec_ff   <= '0;
         tot_nsec_ff  <= '0;
         min_sec_ff   <= '1;
         min_nsec_ff  <= '1;
         max_sec_ff   <= '0;
         max_nsec_ff  <= '0;
         sat_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            tot_sec_ff  <= tot_sec_in;
            tot_nsec_ff <= tot_nsec_in;
            min_sec_ff  <= min_sec_in;
            min_nsec_ff <= min_nsec_in;
            max_sec_ff  <= max_sec_in;
            max_nsec_ff <= max_nsec_in;
            sat_ff      <= sat_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff <= req_chan.op;
         in_ss_ff <= req_chan.start_sec;
         in_sn_ff <= clamp_ns(req_chan.start_nsec);
         in_es_ff <= req_chan.end_sec;
         in_en_ff <= clamp_ns(req_chan.end_nsec);
      end
      if (advance) begin
         delta_sec_ff   <= delta_sec_in;
         delta_nsec_ff  <= delta_nsec_in;
         order_error_ff <= order_error_in;
      end
   end

   // result channel
   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.delta_sec       = delta_sec_ff;
   assign rsp_chan.delta_nsec      = delta_nsec_ff;
   assign rsp_chan.total_sec       = tot_sec_ff;
   assign rsp_chan.total_nsec      = tot_nsec_ff;
   assign rsp_chan.min_sec         = min_sec_ff;
   assign rsp_chan.min_nsec        = min_nsec_ff;
   assign rsp_chan.max_sec         = max_sec_ff;
   assign rsp_chan.max_nsec        = max_nsec_ff;
   assign rsp_chan.total_saturated = sat_ff;
   assign rsp_chan.order_error     = order_error_ff;

endmodule

`default_nettype wire

[rtl/core/ilst_checker.sv]
// ----------------------------------------------------------------------------
// ilst_checker
// Port-level checks on the stats tracker results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ilst_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire ilst_pkg::sec_type     delta_sec,
   input wire ilst_pkg::nsec_type    delta_nsec,
   input wire ilst_pkg::tot_sec_type total_sec,
   input wire ilst_pkg::nsec_type    total_nsec,
   input wire logic                  total_saturated,
   input wire logic                  order_error
);

   // a rejected item reports a zero interval
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && order_error) |-> (delta_sec == '0 && delta_nsec == '0))
      else $error("order error with nonzero interval");

   // a saturated total sits at its ceiling
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && total_saturated) |->
         (total_sec == ilst_pkg::TOT_SEC_MAX && total_nsec == ilst_pkg::NS_MAX))
      else $error("saturated total not at ceiling");

   // accumulated nanoseconds stay normalized
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (total_nsec <= ilst_pkg::NS_MAX))
      else $error("total nanoseconds out of range");

   // no result comes out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a held result stays offered
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

endmodule

bind interval_latency_stats_tracker_unit ilst_checker u_ilst_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .delta_sec       (rsp_chan.delta_sec),
   .delta_nsec      (rsp_chan.delta_nsec),
   .total_sec       (rsp_chan.total_sec),
   .total_nsec      (rsp_chan.total_nsec),
   .total_saturated (rsp_chan.total_saturated),
   .order_error     (rsp_chan.order_error)
);

`default_nettype wire

[sim/interval_latency_stats_tracker_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interval_latency_stats_tracker_unit_test
// Self-checking bench for the interval latency stats tracker. Timestamp pairs
// go in on the request channel with random gaps. A scoreboard keeps its own
// running total, minimum, maximum and saturation flag, and checks every
// statistics result field by field. Directed corner cases come first, then a
// long saturating accumulation, then random init/accumulate sequences.
// ----------------------------------------------------------------------------

module interval_latency_stats_tracker_unit_test;

   import ilst_pkg::*;

   // expected or observed contents of one result item
   typedef struct {
      sec_type     delta_sec;
      nsec_type    delta_nsec;
      tot_sec_type total_sec;
      nsec_type    total_nsec;
      sec_type     min_sec;
      nsec_type    min_nsec;
      sec_type     max_sec;
      nsec_type    max_nsec;
      logic        total_saturated;
      logic        order_error;
   } stats_result_type;

   // kinds of timestamp pairs the random part draws from
   typedef enum int {
      SHAPE_SHORT, SHAPE_WIDE, SHAPE_SAME_SEC, SHAPE_REVERSED, SHAPE_HUGE, SHAPE_NOISE
   } shape_type;

   localparam logic [63:0] ONE_SEC_NS = 64'd1_000_000_000;

   // -------------------------------------------------------------------------
   // scoreboard: running statistics and queue of pending results
   // -------------------------------------------------------------------------
   class interval_stats_board;
      tot_sec_type      acc_sec;
      nsec_type         acc_nsec;
      sec_type          lo_sec;
      nsec_type         lo_nsec;
      sec_type          hi_sec;
      nsec_type         hi_nsec;
      bit               sat;
      stats_result_type pending_stats_q[$];
      int unsigned      mismatches;
      int unsigned      init_count;
      int unsigned      accum_count;
      int unsigned      order_errors;
      int unsigned      saturated_results;

      function new();
         acc_sec           = '0;
         acc_nsec          = '0;
         lo_sec            = '1;
         lo_nsec           = '1;
         hi_sec            = '0;
         hi_nsec           = '0;
         sat               = 1'b0;
         mismatches        = 0;
         init_count        = 0;
         accum_count       = 0;
         order_errors      = 0;
         saturated_results = 0;
      endfunction

      function int unsigned pending();
         return pending_stats_q.size();
      endfunction

      // out-of-range nanoseconds clip to the last valid value
      function logic [63:0] clip_ns(nsec_type v);
         return (v > NS_MAX) ? 64'(NS_MAX) : 64'(v);
      endfunction

      // (as, an) strictly earlier than (bs, bn)
      function bit earlier(logic [63:0] as, logic [63:0] an, logic [63:0] bs,
                           logic [63:0] bn);
         return (as < bs) || (as == bs && an < bn);
      endfunction

      function void saturate();
         acc_sec  = TOT_SEC_MAX;
         acc_nsec = NS_MAX;
         sat      = 1'b1;
      endfunction

      // update statistics for one accepted item and queue its result
      function void note_interval(op_type op, sec_type ss, nsec_type sn_raw, sec_type es,
                                  nsec_type en_raw);
         logic [63:0]      sn;
         logic [63:0]      en;
         logic [63:0]      ds;
         logic [63:0]      dn;
         logic [63:0]      ns;
         logic [63:0]      s;
         bit               err;
         stats_result_type r;
         sn  = clip_ns(sn_raw);
         en  = clip_ns(en_raw);
         ds  = '0;
         dn  = '0;
         err = earlier(64'(es), en, 64'(ss), sn);
         if (err) begin
            order_errors++;
         end else begin
            // interval with nanosecond borrow
            if (en < sn) begin
               ds = 64'(es) - 64'(ss) - 64'd1;
               dn = ONE_SEC_NS + en - sn;
            end else begin
               ds = 64'(es) - 64'(ss);
               dn = en - sn;
            end
            if (op == OP_INIT) begin
               init_count++;
               sat = 1'b0;
               if (ds > 64'(TOT_SEC_MAX)) begin
                  saturate();
               end else begin
                  acc_sec  = tot_sec_type'(ds);
                  acc_nsec = nsec_type'(dn);
               end
               lo_sec  = sec_type'(ds);
               lo_nsec = nsec_type'(dn);
               hi_sec  = sec_type'(ds);
               hi_nsec = nsec_type'(dn);
            end else begin
               accum_count++;
               // add with nanosecond carry, saturating seconds
               ns = 64'(acc_nsec) + dn;
               s  = 64'(acc_sec) + ds;
               if (ns >= ONE_SEC_NS) begin
                  ns = ns - ONE_SEC_NS;
                  s  = s + 64'd1;
               end
               if (s > 64'(TOT_SEC_MAX)) begin
                  saturate();
               end else begin
                  acc_sec  = tot_sec_type'(s);
                  acc_nsec = nsec_type'(ns);
               end
               if (earlier(ds, dn, 64'(lo_sec), 64'(lo_nsec))) begin
                  lo_sec  = sec_type'(ds);
                  lo_nsec = nsec_type'(dn);
               end
               if (earlier(64'(hi_sec), 64'(hi_nsec), ds, dn)) begin
                  hi_sec  = sec_type'(ds);
                  hi_nsec = nsec_type'(dn);
               end
            end
         end
         r.delta_sec       = sec_type'(ds);
         r.delta_nsec      = nsec_type'(dn);
         r.total_sec       = acc_sec;
         r.total_nsec      = acc_nsec;
         r.min_sec         = lo_sec;
         r.min_nsec        = lo_nsec;
         r.max_sec         = hi_sec;
         r.max_nsec        = hi_nsec;
         r.total_saturated = sat;
         r.order_error     = err;
         if (sat) saturated_results++;
         pending_stats_q.push_back(r);
      endfunction

      task report_mismatch(string what);
         $display("%0t ns: %s", $time, what);
         mismatches++;
      endtask

      task compare_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
      endtask

      // compare one result item with the oldest expectation
      task check_stats(stats_result_type got);
         stats_result_type want;
         if (pending_stats_q.size() == 0) begin
            report_mismatch("result item with nothing expected");
         end else begin
            want = pending_stats_q.pop_front();
            compare_field("delta_sec", got.delta_sec, want.delta_sec);
            compare_field("delta_nsec", got.delta_nsec, want.delta_nsec);
            compare_field("total_sec", got.total_sec, want.total_sec);
            compare_field("total_nsec", got.total_nsec, want.total_nsec);
            compare_field("min_sec", got.min_sec, want.min_sec);
            compare_field("min_nsec", got.min_nsec, want.min_nsec);
            compare_field("max_sec", got.max_sec, want.max_sec);
            compare_field("max_nsec", got.max_nsec, want.max_nsec);
            compare_field("total_saturated", got.total_saturated, want.total_saturated);
            compare_field("order_error", got.order_error, want.order_error);
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // clock, reset, channels and block
   // -------------------------------------------------------------------------
   logic clock;
   logic reset;

   ilst_req_if req_chan ();
   ilst_rsp_if rsp_chan ();

   interval_latency_stats_tracker_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   interval_stats_board board = new();
   int unsigned         items_sent    = 0;
   int unsigned         send_idle_pct = 0;
   int unsigned         take_idle_pct = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("interval_latency_stats_tracker_unit: mismatch");
      $finish;
   end

   // result side ready with random stall bursts
   initial begin
      int unsigned stall_left;
      stall_left    = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (take_idle_pct != 0 && $urandom_range(1, 100) <= take_idle_pct) begin
            rsp_chan.ready <= 1'b0;
            stall_left = $urandom_range(1, 13) - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      stats_result_type got;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got.delta_sec       = rsp_chan.delta_sec;
         got.delta_nsec      = rsp_chan.delta_nsec;
         got.total_sec       = rsp_chan.total_sec;
         got.total_nsec      = rsp_chan.total_nsec;
         got.min_sec         = rsp_chan.min_sec;
         got.min_nsec        = rsp_chan.min_nsec;
         got.max_sec         = rsp_chan.max_sec;
         got.max_nsec        = rsp_chan.max_nsec;
         got.total_saturated = rsp_chan.total_saturated;
         got.order_error     = rsp_chan.order_error;
         board.check_stats(got);
      end
   end

   // -------------------------------------------------------------------------
   // request driving, called at a falling edge and returns at one
   // -------------------------------------------------------------------------
   task automatic send_item(op_type op, sec_type ss, nsec_type sn, sec_type es,
                            nsec_type en);
      if (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.op         <= op;
      req_chan.start_sec  <= ss;
      req_chan.start_nsec <= sn;
      req_chan.end_sec    <= es;
      req_chan.end_nsec   <= en;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      board.note_interval(op, ss, sn, es, en);
      items_sent++;
      @(negedge clock);
   endtask

   // mostly valid nanoseconds, a few out of range
   function automatic nsec_type random_ns();
      if ($urandom_range(0, 99) < 5)
         return nsec_type'($urandom_range(1_000_000_000, 32'h3FFF_FFFF));
      return nsec_type'($urandom_range(0, 999_999_999));
   endfunction

   function automatic shape_type pick_shape();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return SHAPE_SHORT;
      if (r < 58) return SHAPE_WIDE;
      if (r < 70) return SHAPE_SAME_SEC;
      if (r < 82) return SHAPE_REVERSED;
      if (r < 88) return SHAPE_HUGE;
      return SHAPE_NOISE;
   endfunction

   task automatic send_shaped(op_type op, shape_type shape);
      sec_type  ss;
      sec_type  es;
      nsec_type sn;
      nsec_type en;
      ss = $urandom;
      es = ss;
      sn = random_ns();
      en = random_ns();
      case (shape)
         SHAPE_SHORT: begin
            ss = $urandom_range(0, 32'hFFFF_FFF0);
            es = ss + $urandom_range(0, 3);
         end
         SHAPE_WIDE: begin
            ss = $urandom_range(0, 1000);
            es = $urandom;
         end
         SHAPE_SAME_SEC: begin
            es = ss;
         end
         SHAPE_REVERSED: begin
            ss = $urandom_range(5, 32'hFFFF_FFFF);
            es = ss - $urandom_range(1, 5);
         end
         SHAPE_HUGE: begin
            ss = $urandom_range(0, 255);
            es = $urandom_range(32'hFFFF_FF00, 32'hFFFF_FFFF);
         end
         default: begin
            es = $urandom;
            sn = nsec_type'($urandom);
            en = nsec_type'($urandom);
         end
      endcase
      send_item(op, ss, sn, es, en);
   endtask

   // stop offering items and wait until every expected result is back
   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------
   initial begin
      int unsigned seg_len;
      int unsigned drain_cycles;
      op_type      op;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.op         = OP_INIT;
      req_chan.start_sec  = '0;
      req_chan.start_nsec = '0;
      req_chan.end_sec    = '0;
      req_chan.end_nsec   = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed corner cases, light idling
      send_idle_pct = 20;
      take_idle_pct = 20;
      // accumulate before any initialise takes the first interval as minimum
      send_item(OP_ACCUM, 32'd0, 30'd0, 32'd5, 30'd500);
      send_item(OP_ACCUM, 32'd9, 30'd7, 32'd9, 30'd7);
      // widest possible interval
      send_item(OP_INIT, 32'd0, 30'd0, 32'hFFFF_FFFF, 30'd999_999_999);
      send_item(OP_ACCUM, 32'hFFFF_FFFF, 30'd999_999_999, 32'hFFFF_FFFF, 30'd999_999_999);
      // nanosecond borrow
      send_item(OP_INIT, 32'd10, 30'd900_000_000, 32'd11, 30'd100_000_000);
      // nanosecond carry into total seconds
      send_item(OP_ACCUM, 32'd0, 30'd0, 32'd0, 30'd999_999_999);
      send_item(OP_ACCUM, 32'd3, 30'd1, 32'd4, 30'd0);
      // end before start, by seconds and by nanoseconds
      send_item(OP_ACCUM, 32'd100, 30'd0, 32'd99, 30'd999_999_999);
      send_item(OP_INIT, 32'd5, 30'd500, 32'd5, 30'd499);
      send_item(OP_INIT, 32'hFFFF_FFFF, 30'd0, 32'd0, 30'd0);
      // out-of-range nanoseconds clip to the last valid value
      send_item(OP_ACCUM, 32'd1, 30'h3FFF_FFFF, 32'd2, 30'd1_000_000_000);
      send_item(OP_ACCUM, 32'd7, 30'd999_999_999, 32'd7, 30'h3FFF_FFFF);
      send_item(OP_ACCUM, 32'd7, 30'h3FFF_FFFF, 32'd7, 30'd5);
      send_item(OP_ACCUM, 32'hAAAA_AAAA, 30'h2AAA_AAAA, 32'hAAAA_AAAB, 30'h1555_5555);
      send_item(OP_ACCUM, 32'h5555_5555, 30'h1555_5555, 32'hFFFF_FFFE, 30'h2AAA_AAAA);
      // zero interval initialise, then new maximum
      send_item(OP_INIT, 32'd0, 30'd0, 32'd0, 30'd0);
      send_item(OP_ACCUM, 32'd0, 30'd0, 32'd1, 30'd1);
      send_item(OP_ACCUM, 32'd0, 30'd1, 32'd0, 30'd0);

      // hold off until every result is back
      wait_for_drain();

      // long run of huge intervals to saturate the total, flag stays set
      send_idle_pct = 10;
      take_idle_pct = 10;
      send_shaped(OP_INIT, SHAPE_HUGE);
      repeat (275) begin
         if ($urandom_range(0, 99) < 94) send_shaped(OP_ACCUM, SHAPE_HUGE);
         else send_shaped(OP_ACCUM, pick_shape());
      end
      wait_for_drain();
      send_shaped(OP_INIT, SHAPE_SHORT);

      // random init/accumulate sequences
      while (items_sent < 860) begin
         if (items_sent > 760) begin
            send_idle_pct = 0;
            take_idle_pct = 0;
         end else begin
            case ($urandom_range(0, 2))
               0: send_idle_pct = 0;
               1: send_idle_pct = 10;
               default: send_idle_pct = 35;
            endcase
            case ($urandom_range(0, 2))
               0: take_idle_pct = 0;
               1: take_idle_pct = 10;
               default: take_idle_pct = 35;
            endcase
         end
         seg_len = $urandom_range(3, 30);
         if ($urandom_range(0, 99) < 85) send_shaped(OP_INIT, pick_shape());
         repeat (seg_len) begin
            op = ($urandom_range(0, 99) < 90) ? OP_ACCUM : OP_INIT;
            send_shaped(op, pick_shape());
         end
      end

      // drain and let the pipeline settle
      wait_for_drain();
      drain_cycles = 0;
      while (drain_cycles < 10) begin
         @(posedge clock);
         drain_cycles++;
      end
      if (board.pending() != 0)
         board.report_mismatch($sformatf("%0d results never arrived", board.pending()));

      $display("run covered %0d items: %0d initialise, %0d accumulate, %0d out of order",
               items_sent, board.init_count, board.accum_count, board.order_errors);
      $display("%0d results carried a saturated total", board.saturated_results);
      if (board.mismatches == 0) begin
         $display("interval_latency_stats_tracker_unit: match");
      end else begin
         $display("interval_latency_stats_tracker_unit: mismatch");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/ilst_pkg.sv
rtl/core/ilst_if.sv
rtl/core/interval_latency_stats_tracker_unit.sv
rtl/core/ilst_checker.sv
sim/interval_latency_stats_tracker_unit_test.sv
